>>> sv/text_console_writer_assert.svh
// Assertion macros for the text console writer; clocked on clk, off during reset.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/tcw_pkg.sv
// Shared types and constants for the text console writer.
`default_nettype none

package tcw_pkg;

	// Default screen geometry
	localparam int DEF_COLUMNS = 80;
	localparam int DEF_ROWS    = 25;

	// Fixed field widths
	localparam int COL_W     = 7;
	localparam int ROW_W     = 5;
	localparam int CHAR_W    = 8;
	localparam int COLOR_W   = 4;
	localparam int CELL_W    = 16;
	localparam int MODE_W    = 2;
	localparam int CFG_IDX_W = 1;

	localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'h0A;
	localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'h20;
	localparam logic [COLOR_W-1:0] FG_RESET     = 4'd7;
	localparam logic [COLOR_W-1:0] BG_RESET     = 4'd0;

	// Request opcodes
	typedef enum logic [MODE_W-1:0] {
		MODE_PUT   = 2'd0,
		MODE_CLEAR = 2'd1,
		MODE_READ  = 2'd2
	} mode_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FG = 1'b0,
		CFG_BG = 1'b1
	} cfg_reg_t;

	// Controller state: normal operation or a fill sweep over the store
	typedef enum logic {
		CTRL_RUN,
		CTRL_SWEEP
	} ctrl_state_t;

	// Finished result handed from the controller to the output register
	typedef struct packed {
		logic              valid;
		logic [CELL_W-1:0] word;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
	} res_t;

	// Controller status
	typedef struct packed {
		logic busy;
		logic pending;
	} ctrl_stat_t;

endpackage

`default_nettype wire

>>> sv/tcw_screen_mem.sv
// Screen cell store: one write port, one registered read port.
`default_nettype none

module tcw_screen_mem import tcw_pkg::*; #(
	parameter int DEPTH  = DEF_COLUMNS * DEF_ROWS,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [CELL_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [CELL_W-1:0] rdata
);

	logic [CELL_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port; data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> sv/tcw_ctrl.sv
// Console controller: caret, scroll pointer, colors, fill sweeper and result stage.
`default_nettype none

module tcw_ctrl import tcw_pkg::*; #(
	parameter int SCREEN_COLUMNS = DEF_COLUMNS,
	parameter int SCREEN_ROWS    = DEF_ROWS,
	parameter int DEPTH          = SCREEN_COLUMNS * SCREEN_ROWS,
	parameter int ADDR_W         = $clog2(DEPTH)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [COLOR_W-1:0]   cfg_data,
	// request channel
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [MODE_W-1:0]    mode,
	input  wire logic [CHAR_W-1:0]    char_code,
	input  wire logic [COL_W-1:0]     cell_column,
	input  wire logic [ROW_W-1:0]     cell_row,
	// result toward the output register
	output res_t                      res,
	input  wire logic                 res_ready,
	output ctrl_stat_t                stat,
	// memory
	output logic                      mem_we,
	output logic      [ADDR_W-1:0]    mem_waddr,
	output logic      [CELL_W-1:0]    mem_wdata,
	output logic                      mem_re,
	output logic      [ADDR_W-1:0]    mem_raddr,
	input  wire logic [CELL_W-1:0]    mem_rdata
);

	localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(SCREEN_COLUMNS - 1);
	localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(SCREEN_ROWS - 1);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
	localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(SCREEN_COLUMNS);
	localparam logic [ADDR_W-1:0] LAST_COLA = ADDR_W'(SCREEN_COLUMNS - 1);

	// screen row plus top pointer, wrapped once into the ring of rows
	function automatic logic [ROW_W-1:0] phys_row(logic [ROW_W-1:0] r, logic [ROW_W-1:0] top);
		logic [ROW_W:0] sum;
		sum = {1'b0, r} + {1'b0, top};
		if (sum >= (ROW_W+1)'(SCREEN_ROWS)) begin
			sum = sum - (ROW_W+1)'(SCREEN_ROWS);
		end
		return sum[ROW_W-1:0];
	endfunction

	ctrl_state_t state_q, state_d;

	logic [COLOR_W-1:0] fg_q, bg_q;
	logic [COL_W-1:0]   caret_col_q, col_d;
	logic [ROW_W-1:0]   caret_row_q, row_d;
	logic [ROW_W-1:0]   top_q, top_d;

	logic [ADDR_W-1:0] sweep_addr_q, sweep_last_q;
	logic [CELL_W-1:0] fill_q;

	logic              s1_valid_q;
	logic              hit_s1;
	logic [COL_W-1:0]  caret_col_s1;
	logic [ROW_W-1:0]  caret_row_s1;

	logic              accept;
	logic              put_wr, rd_hit, start_scroll, start_full;
	logic [ADDR_W-1:0] caret_addr, read_addr, row_base;
	logic [CELL_W-1:0] blank_cell, put_cell;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != CTRL_RUN) || (s1_valid_q && !res_ready);

	assign blank_cell = {bg_q, fg_q, SPACE_CODE};
	assign put_cell   = {bg_q, fg_q, char_code};

	// store addresses of the caret, the read cell and the row leaving the top
	assign caret_addr = ADDR_W'(phys_row(caret_row_q, top_q)) * COLS_A + ADDR_W'(caret_col_q);
	assign read_addr  = ADDR_W'(phys_row(cell_row, top_q)) * COLS_A + ADDR_W'(cell_column);
	assign row_base   = ADDR_W'(top_q) * COLS_A;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= FG_RESET;
			bg_q <= BG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_FG: fg_q <= cfg_data;
				CFG_BG: bg_q <= cfg_data;
			endcase
		end
	end

	// request decode: caret motion, scroll and clear
	always_comb begin
		logic adv;
		adv          = 1'b0;
		col_d        = caret_col_q;
		row_d        = caret_row_q;
		top_d        = top_q;
		put_wr       = 1'b0;
		rd_hit       = 1'b0;
		start_scroll = 1'b0;
		start_full   = 1'b0;
		if (accept) begin
			unique case (mode)
				MODE_PUT: begin
					if (char_code == NEWLINE_CODE) begin
						col_d = '0;
						adv   = 1'b1;
					end else begin
						put_wr = 1'b1;
						if (caret_col_q == LAST_COL) begin
							col_d = '0;
							adv   = 1'b1;
						end else begin
							col_d = caret_col_q + 1'b1;
						end
					end
				end
				MODE_CLEAR: begin
					col_d      = '0;
					row_d      = '0;
					top_d      = '0;
					start_full = 1'b1;
				end
				MODE_READ: begin
					rd_hit = ({1'b0, cell_column} < (COL_W+1)'(SCREEN_COLUMNS)) &&
					         ({1'b0, cell_row} < (ROW_W+1)'(SCREEN_ROWS));
				end
				default: ;
			endcase
			// row advance; past the last row the screen scrolls
			if (adv) begin
				if (caret_row_q == LAST_ROW) begin
					top_d        = (top_q == LAST_ROW) ? '0 : top_q + 1'b1;
					start_scroll = 1'b1;
				end else begin
					row_d = caret_row_q + 1'b1;
				end
			end
		end
	end

	// caret and top pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			caret_col_q <= '0;
			caret_row_q <= '0;
			top_q       <= '0;
		end else begin
			caret_col_q <= col_d;
			caret_row_q <= row_d;
			top_q       <= top_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CTRL_RUN: begin
				if (start_scroll || start_full) begin
					state_d = CTRL_SWEEP;
				end
			end
			CTRL_SWEEP: begin
				if (sweep_addr_q == sweep_last_q) begin
					state_d = CTRL_RUN;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CTRL_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	// sweeper: reset zeroes the whole store, clear blanks it, scroll blanks the old top row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_addr_q <= '0;
			sweep_last_q <= LAST_ADDR;
			fill_q       <= '0;
		end else if (start_scroll) begin
			sweep_addr_q <= row_base;
			sweep_last_q <= row_base + LAST_COLA;
			fill_q       <= blank_cell;
		end else if (start_full) begin
			sweep_addr_q <= '0;
			sweep_last_q <= LAST_ADDR;
			fill_q       <= blank_cell;
		end else if (state_q == CTRL_SWEEP) begin
			sweep_addr_q <= sweep_addr_q + 1'b1;
		end
	end

	// memory port drive; a sweep and a put never share a cycle
	always_comb begin
		if (state_q == CTRL_SWEEP) begin
			mem_we    = 1'b1;
			mem_waddr = sweep_addr_q;
			mem_wdata = fill_q;
		end else begin
			mem_we    = put_wr;
			mem_waddr = caret_addr;
			mem_wdata = put_cell;
		end
		mem_re      = rd_hit;
		mem_raddr   = read_addr;
		stat.busy    = (state_q == CTRL_SWEEP);
		stat.pending = s1_valid_q;
	end

	// result stage: read data from the registered store port arrives here in the cycle after the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (res_ready) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hit_s1       <= rd_hit;
			caret_col_s1 <= col_d;
			caret_row_s1 <= row_d;
		end
	end

	assign res.valid = s1_valid_q;
	assign res.word  = hit_s1 ? mem_rdata : '0;
	assign res.col   = caret_col_s1;
	assign res.row   = caret_row_s1;

endmodule

`default_nettype wire

>>> sv/text_console_writer.sv
// A result passes through the controller's result stage and then the output register.
// Throughput: one put or read a cycle while in_stall is low; the store has one write and one read port.
// A scroll stalls requests while the sweeper blanks a row.
// A clear stalls requests while the sweeper blanks the whole store.
// Reset: caret home, colors 7 on 0, then a pass that zeroes the whole store.
`default_nettype none
`include "text_console_writer_assert.svh"

module text_console_writer import tcw_pkg::*; #(
	parameter int SCREEN_COLUMNS = DEF_COLUMNS,
	parameter int SCREEN_ROWS    = DEF_ROWS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [COLOR_W-1:0]   cfg_data,
	// requests
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [MODE_W-1:0]    mode,
	input  wire logic [CHAR_W-1:0]    char_code,
	input  wire logic [COL_W-1:0]     cell_column,
	input  wire logic [ROW_W-1:0]     cell_row,
	// results
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic      [CELL_W-1:0]    cell_word,
	output logic      [COL_W-1:0]     caret_column,
	output logic      [ROW_W-1:0]     caret_row
);

	localparam int DEPTH  = SCREEN_COLUMNS * SCREEN_ROWS;
	localparam int ADDR_W = $clog2(DEPTH);

	res_t              res;
	ctrl_stat_t        stat;
	logic              out_free;
	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	logic [CELL_W-1:0] mem_wdata, mem_rdata;
	logic              req_clear, caret_ok, res_blocked;

	tcw_ctrl #(
		.SCREEN_COLUMNS (SCREEN_COLUMNS),
		.SCREEN_ROWS    (SCREEN_ROWS),
		.DEPTH          (DEPTH),
		.ADDR_W         (ADDR_W)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.char_code   (char_code),
		.cell_column (cell_column),
		.cell_row    (cell_row),
		.res         (res),
		.res_ready   (out_free),
		.stat        (stat),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_re      (mem_re),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata)
	);

	tcw_screen_mem #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output register separates the result side from the request side
	assign out_free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res.valid) begin
			cell_word    <= res.word;
			caret_column <= res.col;
			caret_row    <= res.row;
		end
	end

	// check terms
	assign req_clear   = in_valid && !in_stall && (mode == MODE_CLEAR);
	assign caret_ok    = ({1'b0, caret_column} < (COL_W+1)'(SCREEN_COLUMNS)) &&
	                     ({1'b0, caret_row} < (ROW_W+1)'(SCREEN_ROWS));
	assign res_blocked = stat.pending && out_valid && out_stall;

	// checks
	`TCW_ASSERT_NOW(a_sweep_blocks_requests, stat.busy, in_stall, "request taken during sweep")
	`TCW_ASSERT_NEXT(a_clear_starts_sweep, req_clear, stat.busy, "clear did not start a sweep")
	`TCW_ASSERT_NOW(a_caret_in_screen, out_valid, caret_ok, "caret off screen")
	`TCW_ASSERT_NOW(a_blocked_result_stalls, res_blocked, in_stall, "request over held result")

endmodule

`default_nettype wire
